// ===== design/slps_pkg.sv =====
// Package for the status LED pattern sequencer.
// Holds the mode codes, the counter width and the sequencer state type.
// No dependencies.
package slps_pkg;

  // Width of the wrapping tick counter (valid range 4 to 16).
  localparam int COUNT_WIDTH = 8;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [4:0] mode_t;

  // Mode codes carried in a mode message.
  localparam mode_t M_OFF       = 5'd0;
  localparam mode_t M_IDLE      = 5'd1;
  localparam mode_t M_CONNECTED = 5'd2;
  localparam mode_t M_WATCHDOG  = 5'd3;
  localparam mode_t M_BAT0      = 5'd4;
  localparam mode_t M_BAT1      = 5'd5;
  localparam mode_t M_BAT2      = 5'd6;
  localparam mode_t M_BAT3      = 5'd7;
  localparam mode_t M_BAT4      = 5'd8;
  localparam mode_t M_BAT5      = 5'd9;
  localparam mode_t M_CHG0      = 5'd10;
  localparam mode_t M_CHG1      = 5'd11;
  localparam mode_t M_CHG2      = 5'd12;
  localparam mode_t M_CHG3      = 5'd13;
  localparam mode_t M_CHG4      = 5'd14;
  localparam mode_t M_CHG5      = 5'd15;
  localparam mode_t M_ERROR     = 5'd16;
  localparam mode_t M_CMD_OK    = 5'd17;
  localparam mode_t M_CMD_ERR   = 5'd18;
  localparam mode_t M_CMD_UNK   = 5'd19;

  // Complete sequencer state, updated once per accepted tick.
  typedef struct packed {
    mode_t cur_mode;
    mode_t prev_mode;
    cnt_t  tick_count;
    logic  armed;
    logic  green;
    logic  yellow;
    logic  red;
  } state_t;

endpackage

// ===== design/status_led_pattern_sequencer.sv =====
// Top level of the status LED pattern sequencer: stream ports, state
// registers and the output register. Depends on slps_pkg and slps_rule.
//
// An accepted tick's LED result is pending in the next cycle; throughput is
// one tick per cycle while m_tready holds, the single output register being
// refilled in the cycle it is taken. Reset (rst, synchronous, active high)
// sets mode off, counter zero, one-shot armed, all LEDs off, no result pending.
module status_led_pattern_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [0] mode_valid, [5:1] new_mode, [7:6] zero
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] green_on, [1] yellow_on, [2] red_on, [7:3] zero
);
  import slps_pkg::*;

  state_t st;
  state_t st_next;
  logic   accept;

  // A request is taken whenever the output register is empty or drains now.
  assign s_tready = ~m_tvalid | m_tready;
  assign accept   = s_tvalid & s_tready;

  slps_rule u_rule (
    .st         (st),
    .mode_valid (s_tdata[0]),
    .new_mode   (s_tdata[5:1]),
    .nx         (st_next)
  );

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.cur_mode   <= M_OFF;
      st.prev_mode  <= M_OFF;
      st.tick_count <= '0;
      st.armed      <= 1'b1;
      st.green      <= 1'b0;
      st.yellow     <= 1'b0;
      st.red        <= 1'b0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {5'b0, st_next.red, st_next.yellow, st_next.green};
    end
  end

`ifndef ASSERT_OFF
  // Every accepted tick leaves a result pending in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted tick produced no result");

  // A message for the connected mode lights green on that tick.
  a_connected_green: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tdata[0] && s_tdata[5:1] == M_CONNECTED) |=> m_tdata[0])
    else $error("connected mode did not light green");

  // In the off mode every LED is dark.
  a_off_dark: assert property (@(posedge clk) disable iff (rst)
    (st.cur_mode == M_OFF) |-> (!st.green && !st.yellow && !st.red))
    else $error("LED lit in off mode");

  // A result that waits is not overwritten.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("pending result changed");
`endif

endmodule

// ===== design/slps_rule.sv =====
// Next-state logic of the status LED pattern sequencer for one tick.
// Pure combinational; depends on slps_pkg for mode codes and the state type.
module slps_rule (
  input  slps_pkg::state_t st,
  input  logic             mode_valid,
  input  slps_pkg::mode_t  new_mode,
  output slps_pkg::state_t nx
);
  import slps_pkg::*;

  always_comb begin
    // Advance the counter, then apply any mode message.
    nx = st;
    nx.tick_count = st.tick_count + cnt_t'(1);
    if (mode_valid) begin
      nx.cur_mode = new_mode;
      if (new_mode != st.prev_mode) begin
        nx.prev_mode  = new_mode;
        nx.green      = 1'b0;
        nx.yellow     = 1'b0;
        nx.red        = 1'b0;
        nx.tick_count = '0;
      end
      if (new_mode >= M_CMD_OK && new_mode <= M_CMD_UNK) begin
        nx.armed      = 1'b1;
        nx.tick_count = '0;
      end
    end

    // Apply the rule of the current mode.
    unique case (nx.cur_mode)
      M_OFF: begin
        nx.green  = 1'b0;
        nx.yellow = 1'b0;
        nx.red    = 1'b0;
      end
      M_IDLE: begin
        if (nx.tick_count < cnt_t'(5)) nx.green = 1'b1;
        else if (nx.tick_count < cnt_t'(10)) nx.green = 1'b0;
        else nx.tick_count = '0;
      end
      M_CONNECTED: nx.green = 1'b1;
      M_WATCHDOG: begin
        if (nx.tick_count < cnt_t'(5)) nx.red = 1'b1;
        else if (nx.tick_count < cnt_t'(10)) nx.red = 1'b0;
        else nx.tick_count = '0;
      end
      M_BAT0: nx.red = ~nx.tick_count[0];
      M_BAT1: nx.red = 1'b1;
      M_BAT2: begin
        nx.red = 1'b1;
        if (nx.tick_count < cnt_t'(3)) nx.yellow = 1'b1;
        else if (nx.tick_count < cnt_t'(6)) nx.yellow = 1'b0;
        else nx.tick_count = '0;
      end
      M_BAT3: begin
        nx.red    = 1'b1;
        nx.yellow = 1'b1;
      end
      M_BAT4, M_CHG4, M_CHG5: begin
        nx.red    = 1'b1;
        nx.yellow = 1'b1;
        if (nx.tick_count < cnt_t'(3)) nx.green = 1'b1;
        else if (nx.tick_count < cnt_t'(6)) nx.green = 1'b0;
        else nx.tick_count = '0;
      end
      M_BAT5: begin
        nx.green  = 1'b1;
        nx.yellow = 1'b1;
        nx.red    = 1'b1;
      end
      M_CHG0, M_CHG1: begin
        if (nx.tick_count < cnt_t'(3)) nx.red = 1'b1;
        else if (nx.tick_count < cnt_t'(6)) nx.yellow = 1'b1;
        else if (nx.tick_count < cnt_t'(9)) nx.green = 1'b1;
        else if (nx.tick_count < cnt_t'(12)) begin
          nx.green  = 1'b0;
          nx.yellow = 1'b0;
          nx.red    = 1'b0;
        end else nx.tick_count = '0;
      end
      M_CHG2, M_CHG3: begin
        nx.red = 1'b1;
        if (nx.tick_count < cnt_t'(3)) nx.yellow = 1'b1;
        else if (nx.tick_count < cnt_t'(6)) nx.green = 1'b1;
        else if (nx.tick_count < cnt_t'(9)) begin
          nx.green  = 1'b0;
          nx.yellow = 1'b0;
        end else nx.tick_count = '0;
      end
      M_ERROR: begin
        if (nx.tick_count < cnt_t'(5)) begin
          nx.green  = 1'b1;
          nx.yellow = 1'b1;
          nx.red    = 1'b1;
        end else if (nx.tick_count < cnt_t'(10)) begin
          nx.green  = 1'b0;
          nx.yellow = 1'b0;
          nx.red    = 1'b0;
        end else nx.tick_count = '0;
      end
      M_CMD_OK, M_CMD_ERR, M_CMD_UNK: begin
        // One-shot flash of the acknowledge LED while the flag is armed.
        if (nx.armed) begin
          if (nx.tick_count < cnt_t'(3)) begin
            if (nx.cur_mode == M_CMD_OK) nx.green = 1'b1;
            else if (nx.cur_mode == M_CMD_ERR) nx.red = 1'b1;
            else nx.yellow = 1'b1;
          end else if (nx.tick_count < cnt_t'(10)) begin
            if (nx.cur_mode == M_CMD_OK) nx.green = 1'b0;
            else if (nx.cur_mode == M_CMD_ERR) nx.red = 1'b0;
            else nx.yellow = 1'b0;
          end else begin
            nx.tick_count = '0;
            nx.armed      = 1'b0;
          end
        end
      end
      default: begin
        // Unused mode numbers hold all LEDs.
      end
    endcase
  end

endmodule
